// ===== design/tlte_pkg.sv =====
package tlte_pkg;

    // Default full block length; a shorter block ends the transfer.
    localparam int BLOCK_BYTES = 512;
    // Depth of the event queue between front and back.
    localparam int EVT_QUEUE_DEPTH = 2;
    // Timeouts tolerated after reset, until retry_limit is written.
    localparam logic [3:0] MAX_RETRIES = 4'd5;

    localparam int BLK_W = 16;
    localparam int LEN_W = 10;
    localparam int PORT_W = 16;
    localparam int RETRY_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CFG_TRANSFER_MODE = 2'd0,
        CFG_PARTNER_PORT  = 2'd1,
        CFG_RETRY_LIMIT   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PACKET  = 2'd1,
        CMD_TIMEOUT = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        OPC_RRQ   = 3'd1,
        OPC_WRQ   = 3'd2,
        OPC_DATA  = 3'd3,
        OPC_ACK   = 3'd4,
        OPC_ERROR = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_DATA  = 3'd1,
        ACT_ACK   = 3'd2,
        ACT_STORE = 3'd3,
        ACT_TID   = 3'd4,
        ACT_OK    = 3'd5,
        ACT_FAIL  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_PEER    = 2'd1,
        CAUSE_RETRIES = 2'd2
    } fail_cause_t;

    // Transfer direction held in transfer_mode.
    typedef enum logic {
        MODE_READ  = 1'b0,
        MODE_WRITE = 1'b1
    } mode_t;

    // Event class decided by the front end, independent of transfer state.
    typedef enum logic [2:0] {
        EV_NOP     = 3'd0,
        EV_START   = 3'd1,
        EV_TID     = 3'd2,
        EV_ERROR   = 3'd3,
        EV_ACK     = 3'd4,
        EV_DATA    = 3'd5,
        EV_TIMEOUT = 3'd6
    } evt_kind_t;

    typedef struct packed {
        evt_kind_t         kind;
        logic [BLK_W-1:0]  pblk;
        logic              pay_short;    // received payload below a full block
        logic [LEN_W-1:0]  chunk;        // clamped chunk length
        logic              chunk_short;  // chunk below a full block
    } evt_t;

    typedef struct packed {
        action_t           action;
        logic [BLK_W-1:0]  block_number;
        logic [LEN_W-1:0]  send_bytes;
        fail_cause_t       fail_cause;
        logic              timer_restart;
        logic              last_result;
    } res_t;

    typedef struct packed {
        logic transfer_mode;
        logic [PORT_W-1:0] partner_port;
        logic [RETRY_W-1:0] retry_limit;
    } cfg_t;

endpackage

// ===== design/tlte_front.sv =====
module tlte_front #(
    parameter int BLOCK_BYTES = tlte_pkg::BLOCK_BYTES
) (
    input  logic                          s_valid,
    input  logic [1:0]                    s_command,
    input  logic [tlte_pkg::PORT_W-1:0]   s_source_port,
    input  logic                          s_packet_ok,
    input  logic [2:0]                    s_packet_opcode,
    input  logic [tlte_pkg::BLK_W-1:0]    s_packet_block,
    input  logic [tlte_pkg::LEN_W-1:0]    s_payload_bytes,
    input  logic [tlte_pkg::LEN_W-1:0]    s_chunk_bytes,
    input  logic [tlte_pkg::PORT_W-1:0]   partner_port,
    input  logic                          q_full,
    output logic                          s_ready,
    output logic                          q_push,
    output tlte_pkg::evt_t                q_evt
);

    localparam int CMP_W = 17;
    localparam logic [CMP_W-1:0] BB = CMP_W'(BLOCK_BYTES);

    logic [CMP_W-1:0] chunk_ext;
    logic [CMP_W-1:0] pay_ext;

    assign chunk_ext = CMP_W'(s_chunk_bytes);
    assign pay_ext   = CMP_W'(s_payload_bytes);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_evt.pblk        = s_packet_block;
        q_evt.pay_short   = pay_ext < BB;
        q_evt.chunk_short = chunk_ext < BB;
        // an oversized chunk saturates at a full block
        q_evt.chunk       = (chunk_ext > BB) ? BB[tlte_pkg::LEN_W-1:0] : s_chunk_bytes;
        q_evt.kind        = tlte_pkg::EV_NOP;
        case (s_command)
            tlte_pkg::CMD_START: begin
                q_evt.kind = tlte_pkg::EV_START;
            end
            tlte_pkg::CMD_PACKET: begin
                if (s_source_port != partner_port) begin
                    q_evt.kind = tlte_pkg::EV_TID;
                end else if (s_packet_ok) begin
                    case (s_packet_opcode)
                        tlte_pkg::OPC_ERROR: q_evt.kind = tlte_pkg::EV_ERROR;
                        tlte_pkg::OPC_ACK:   q_evt.kind = tlte_pkg::EV_ACK;
                        tlte_pkg::OPC_DATA:  q_evt.kind = tlte_pkg::EV_DATA;
                        default:             q_evt.kind = tlte_pkg::EV_NOP;
                    endcase
                end
            end
            tlte_pkg::CMD_TIMEOUT: begin
                q_evt.kind = tlte_pkg::EV_TIMEOUT;
            end
            default: begin
                q_evt.kind = tlte_pkg::EV_NOP;
            end
        endcase
    end

endmodule

// ===== design/tlte_evt_fifo.sv =====
module tlte_evt_fifo #(
    parameter int DEPTH = tlte_pkg::EVT_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tlte_pkg::evt_t push_evt,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output tlte_pkg::evt_t head_evt
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tlte_pkg::evt_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == FULL_CNT;
    assign not_empty = count_reg != '0;
    assign head_evt  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("event queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("event queue underflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("event queue count out of range");

endmodule

// ===== design/tlte_back.sv =====
module tlte_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  tlte_pkg::cfg_t cfg,
    input  logic           q_not_empty,
    input  tlte_pkg::evt_t q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output tlte_pkg::res_t m_res
);

    logic [tlte_pkg::BLK_W-1:0]   blk_reg, blk_next;
    logic [tlte_pkg::RETRY_W-1:0] retry_reg, retry_next;
    logic [tlte_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                         len_short_reg, len_short_next;
    logic                         done_reg, done_next;
    logic                         pend_ok_reg, pend_ok_next;
    logic                         m_valid_reg, m_valid_next;
    tlte_pkg::res_t               res_reg, res_next;

    logic                         out_free;
    logic [tlte_pkg::BLK_W-1:0]   blk_inc;
    tlte_pkg::res_t               r;
    logic                         two_results;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = out_free && !pend_ok_reg && q_not_empty;
    assign blk_inc  = blk_reg + 1'b1;
    assign m_valid  = m_valid_reg;
    assign m_res    = res_reg;

    // Result and state update for the event at the queue head.
    always_comb begin
        blk_next       = blk_reg;
        retry_next     = retry_reg;
        len_next       = len_reg;
        len_short_next = len_short_reg;
        done_next      = done_reg;
        two_results    = 1'b0;
        r              = '0;
        r.action       = tlte_pkg::ACT_NONE;
        r.fail_cause   = tlte_pkg::CAUSE_NONE;

        if (q_head.kind == tlte_pkg::EV_START) begin
            done_next  = 1'b0;
            retry_next = '0;
            r.timer_restart = 1'b1;
            if (cfg.transfer_mode == tlte_pkg::MODE_READ) begin
                blk_next       = 16'd1;
                len_next       = q_head.chunk;
                len_short_next = q_head.chunk_short;
                r.action       = tlte_pkg::ACT_DATA;
                r.block_number = 16'd1;
                r.send_bytes   = q_head.chunk;
            end else begin
                blk_next       = '0;
                len_next       = '0;
                len_short_next = 1'b1;
                r.action       = tlte_pkg::ACT_ACK;
            end
        end else if (!done_reg) begin
            case (q_head.kind)
                tlte_pkg::EV_TID: begin
                    r.action = tlte_pkg::ACT_TID;
                end
                tlte_pkg::EV_ERROR: begin
                    done_next      = 1'b1;
                    r.action       = tlte_pkg::ACT_FAIL;
                    r.block_number = blk_reg;
                    r.fail_cause   = tlte_pkg::CAUSE_PEER;
                end
                tlte_pkg::EV_ACK: begin
                    if (cfg.transfer_mode == tlte_pkg::MODE_READ &&
                        q_head.pblk == blk_reg) begin
                        retry_next = '0;
                        if (len_short_reg) begin
                            done_next      = 1'b1;
                            r.action       = tlte_pkg::ACT_OK;
                            r.block_number = blk_reg;
                        end else begin
                            blk_next        = blk_inc;
                            len_next        = q_head.chunk;
                            len_short_next  = q_head.chunk_short;
                            r.action        = tlte_pkg::ACT_DATA;
                            r.block_number  = blk_inc;
                            r.send_bytes    = q_head.chunk;
                            r.timer_restart = 1'b1;
                        end
                    end
                end
                tlte_pkg::EV_DATA: begin
                    if (cfg.transfer_mode == tlte_pkg::MODE_WRITE) begin
                        if (q_head.pblk == blk_inc) begin
                            blk_next        = blk_inc;
                            retry_next      = '0;
                            r.action        = tlte_pkg::ACT_STORE;
                            r.block_number  = blk_inc;
                            r.timer_restart = !q_head.pay_short;
                            if (q_head.pay_short) begin
                                done_next   = 1'b1;
                                two_results = 1'b1;
                            end
                        end else if (q_head.pblk == blk_reg) begin
                            // duplicate block: re-acknowledge
                            r.action       = tlte_pkg::ACT_ACK;
                            r.block_number = blk_reg;
                        end
                    end
                end
                tlte_pkg::EV_TIMEOUT: begin
                    if (retry_reg >= cfg.retry_limit) begin
                        done_next      = 1'b1;
                        r.action       = tlte_pkg::ACT_FAIL;
                        r.block_number = blk_reg;
                        r.fail_cause   = tlte_pkg::CAUSE_RETRIES;
                    end else begin
                        retry_next      = retry_reg + 1'b1;
                        r.block_number  = blk_reg;
                        r.timer_restart = 1'b1;
                        if (cfg.transfer_mode == tlte_pkg::MODE_READ) begin
                            r.action     = tlte_pkg::ACT_DATA;
                            r.send_bytes = len_reg;
                        end else begin
                            r.action = tlte_pkg::ACT_ACK;
                        end
                    end
                end
                default: begin
                    r.action = tlte_pkg::ACT_NONE;
                end
            endcase
        end
        r.last_result = !two_results;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        pend_ok_next = pend_ok_reg;
        if (out_free) begin
            m_valid_next = 1'b0;
            if (pend_ok_reg) begin
                // second result of a final DATA block
                m_valid_next           = 1'b1;
                pend_ok_next           = 1'b0;
                res_next               = '0;
                res_next.action        = tlte_pkg::ACT_OK;
                res_next.fail_cause    = tlte_pkg::CAUSE_NONE;
                res_next.block_number  = blk_reg;
                res_next.last_result   = 1'b1;
            end else if (q_not_empty) begin
                m_valid_next = 1'b1;
                pend_ok_next = two_results;
                res_next     = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg       <= '0;
            retry_reg     <= '0;
            len_reg       <= '0;
            len_short_reg <= 1'b1;
            done_reg      <= 1'b1;
            pend_ok_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                blk_reg       <= blk_next;
                retry_reg     <= retry_next;
                len_reg       <= len_next;
                len_short_reg <= len_short_next;
                done_reg      <= done_next;
            end
            pend_ok_reg <= pend_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    a_pend_holds_store: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_ok_reg |-> m_valid_reg && res_reg.action == tlte_pkg::ACT_STORE &&
                        !res_reg.last_result)
        else $error("pending done result without store result in flight");

    a_pend_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_ok_reg |-> done_reg)
        else $error("final block pending but transfer not finished");

    a_cause_only_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.fail_cause != tlte_pkg::CAUSE_NONE |->
            res_reg.action == tlte_pkg::ACT_FAIL)
        else $error("fail cause on a non-fail result");

    a_ok_follows_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ready && pend_ok_reg |=>
            m_valid_reg && res_reg.action == tlte_pkg::ACT_OK && res_reg.last_result)
        else $error("done result did not follow final store");

endmodule

// ===== design/tftp_lockstep_transfer_engine_core.sv =====
// Lock-step TFTP transfer controller for one transfer. Each input transaction
// is a start, a parsed packet or a timer expiry; it yields one result
// transaction, or two (store-and-ack then done ok) for the final DATA block in
// write mode, with last_result marking the final one. A front end classifies
// the event (command, source port match, opcode, length saturation) and
// pushes it into a short event queue; the back end owns block number, retry
// count, last chunk length and the done flag, and drives a registered result
// stage. An accepted input passes through the event queue and then the result
// register. With m_ready held high one transaction is accepted every cycle,
// except that the second result of a final DATA block stalls the back end;
// the queue fills behind it and the input sees backpressure. Configuration
// (cfg_wr_en, cfg_index, cfg_wdata) must be written only while the block is
// idle.
module tftp_lockstep_transfer_engine_core #(
    parameter int BLOCK_BYTES     = tlte_pkg::BLOCK_BYTES,
    parameter int EVT_QUEUE_DEPTH = tlte_pkg::EVT_QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [tlte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlte_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // event input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_command,
    input  logic [tlte_pkg::PORT_W-1:0]      s_source_port,
    input  logic                             s_packet_ok,
    input  logic [2:0]                       s_packet_opcode,
    input  logic [tlte_pkg::BLK_W-1:0]       s_packet_block,
    input  logic [tlte_pkg::LEN_W-1:0]       s_payload_bytes,
    input  logic [tlte_pkg::LEN_W-1:0]       s_chunk_bytes,

    // result output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_action,
    output logic [tlte_pkg::BLK_W-1:0]       m_block_number,
    output logic [tlte_pkg::LEN_W-1:0]       m_send_bytes,
    output logic [1:0]                       m_fail_cause,
    output logic                             m_timer_restart,
    output logic                             m_last_result
);

    // configuration registers
    logic                           mode_reg;
    logic [tlte_pkg::PORT_W-1:0]    port_reg;
    logic [tlte_pkg::RETRY_W-1:0]   limit_reg;
    tlte_pkg::cfg_t                 cfg;

    // front <-> queue <-> back
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_not_empty;
    tlte_pkg::evt_t  q_in_evt;
    tlte_pkg::evt_t  q_head_evt;
    tlte_pkg::res_t  res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= tlte_pkg::MODE_READ;
            port_reg  <= '0;
            limit_reg <= tlte_pkg::MAX_RETRIES;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tlte_pkg::CFG_TRANSFER_MODE: mode_reg  <= cfg_wdata[0];
                tlte_pkg::CFG_PARTNER_PORT:  port_reg  <= cfg_wdata;
                tlte_pkg::CFG_RETRY_LIMIT:   limit_reg <= cfg_wdata[tlte_pkg::RETRY_W-1:0];
                default: ;  // unused index: write dropped
            endcase
        end
    end

    assign cfg.transfer_mode = mode_reg;
    assign cfg.partner_port  = port_reg;
    assign cfg.retry_limit   = limit_reg;

    // Front: classify the incoming transaction and push it.
    tlte_front #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_front (
        .s_valid        (s_valid),
        .s_command      (s_command),
        .s_source_port  (s_source_port),
        .s_packet_ok    (s_packet_ok),
        .s_packet_opcode(s_packet_opcode),
        .s_packet_block (s_packet_block),
        .s_payload_bytes(s_payload_bytes),
        .s_chunk_bytes  (s_chunk_bytes),
        .partner_port   (cfg.partner_port),
        .q_full         (q_full),
        .s_ready        (s_ready),
        .q_push         (q_push),
        .q_evt          (q_in_evt)
    );

    // Event queue decouples input stalls from output stalls.
    tlte_evt_fifo #(
        .DEPTH(EVT_QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_evt (q_in_evt),
        .pop      (q_pop),
        .full     (q_full),
        .not_empty(q_not_empty),
        .head_evt (q_head_evt)
    );

    // Back: transfer state and registered result stage.
    tlte_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .q_not_empty(q_not_empty),
        .q_head     (q_head_evt),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (res)
    );

    assign m_action        = res.action;
    assign m_block_number  = res.block_number;
    assign m_send_bytes    = res.send_bytes;
    assign m_fail_cause    = res.fail_cause;
    assign m_timer_restart = res.timer_restart;
    assign m_last_result   = res.last_result;

endmodule
